FILE: rtl/core/ahrq_pkg.sv
// shared types, constants and command structs of the half-plane rectangle query unit
package ahrq_pkg;

	localparam int MAX_PLANES = 256;
	localparam int CNT_W      = $clog2(MAX_PLANES + 1);
	localparam int ADDR_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int STEP_W     = (CNT_W > 6) ? CNT_W : 6;
	localparam int PLANE_W    = 48;
	localparam int AREA_W     = 49;
	localparam int DIV_STEPS  = 48;
	localparam int DIV_LAST   = DIV_STEPS + 2;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] BND_LOX = 2'd0;
	localparam logic [1:0] BND_HIX = 2'd1;
	localparam logic [1:0] BND_LOY = 2'd2;
	localparam logic [1:0] BND_HIY = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] coef_a;
		logic signed [15:0] coef_b;
		logic signed [15:0] coef_c;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
	} in_req_t;

	typedef struct packed {
		logic              inside_res;
		logic [AREA_W-1:0] area;
	} out_rsp_t;

	typedef struct packed {
		logic              load;
		logic              wr;
		logic              rd;
		logic [ADDR_W-1:0] addr;
		logic              cmp;
		logic [1:0]        sel;
		logic              div_sel;
		logic              div_num;
		logic              div_den;
		logic              div_step;
		logic              div_save;
		logic              mul0;
		logic              mul1;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} dp_sts_t;

endpackage

FILE: rtl/core/ahrq_ram.sv
// generic single-write, registered-read ram
module ahrq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/ahrq_dp.sv
// datapath: plane table, scan pipeline, bound registers, divider and area multiply
module ahrq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ahrq_pkg::in_req_t in_data,
	input  ahrq_pkg::dp_cmd_t cmd,
	output ahrq_pkg::dp_sts_t sts,
	output ahrq_pkg::out_rsp_t out_data
);
	localparam int PW = ahrq_pkg::PLANE_W;
	localparam int AW = ahrq_pkg::AREA_W;

	logic signed [31:0] px_q, py_q;
	logic [PW-1:0]      rdata;

	ahrq_ram #(.WIDTH(PW), .DEPTH(ahrq_pkg::MAX_PLANES)) u_table (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (cmd.addr),
		.wdata ({in_data.coef_c, in_data.coef_b, in_data.coef_a}),
		.raddr (cmd.addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= in_data.query_x;
			py_q <= in_data.query_y;
		end
	end

	// stage 1: decode entry, coefficient times point
	logic               rd_s1;
	logic signed [15:0] ea, eb, ec, coef;
	logic               isx;
	logic signed [31:0] pt;
	logic signed [47:0] prod;

	assign ea   = rdata[15:0];
	assign eb   = rdata[31:16];
	assign ec   = rdata[47:32];
	assign isx  = (ea != 16'sd0);
	assign coef = isx ? ea : eb;
	assign pt   = isx ? px_q : py_q;
	assign prod = coef * pt;

	logic               v_s2, isx_s2;
	logic signed [47:0] prod_s2;
	logic signed [15:0] c_s2, coef_s2;

	// stage 2: containment test, bound as fraction
	logic signed [48:0] tst;
	logic               keep, neg;
	logic signed [16:0] n_c, d17;

	assign tst  = {{17{c_s2[15]}}, c_s2, 16'h0} + {prod_s2[47], prod_s2};
	assign keep = (tst <= 49'sd0);
	assign neg  = coef_s2[15];
	assign n_c  = neg ? {c_s2[15], c_s2} : -{c_s2[15], c_s2};
	assign d17  = neg ? -{coef_s2[15], coef_s2} : {coef_s2[15], coef_s2};

	logic               v_s3;
	logic signed [16:0] n_s3;
	logic [15:0]        d_s3;
	logic [1:0]         k_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			v_s2  <= rd_s1 & ((ea != 16'sd0) | (eb != 16'sd0));
			v_s3  <= v_s2 & keep;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		c_s2    <= ec;
		coef_s2 <= coef;
		isx_s2  <= isx;
		n_s3    <= n_c;
		d_s3    <= d17[15:0];
		k_s3    <= {~isx_s2, ~neg};
	end

	// stage 3: tighten the bound of this kind
	logic [3:0]         ok_q;
	logic signed [16:0] bn_q [4];
	logic [15:0]        bd_q [4];
	logic signed [33:0] tl, tr;
	logic               better, upd;

	assign tl     = n_s3 * $signed({1'b0, bd_q[k_s3]});
	assign tr     = bn_q[k_s3] * $signed({1'b0, d_s3});
	assign better = k_s3[0] ? (tl < tr) : (tl > tr);
	assign upd    = v_s3 & (~ok_q[k_s3] | better);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= '0;
		end else if (cmd.load) begin
			ok_q <= '0;
		end else if (upd) begin
			ok_q[k_s3] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			bn_q[k_s3] <= n_s3;
			bd_q[k_s3] <= d_s3;
		end
	end

	// point against bound, one bound a cycle
	logic signed [31:0] cp;
	logic signed [48:0] cl, cr;
	logic [3:0]         gt_q, eq_q;
	logic               corner, inner;

	assign cp = cmd.sel[1] ? py_q : px_q;
	assign cl = cp * $signed({1'b0, bd_q[cmd.sel]});
	assign cr = {{16{bn_q[cmd.sel][16]}}, bn_q[cmd.sel], 16'h0};

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			gt_q[cmd.sel] <= (cl > cr);
			eq_q[cmd.sel] <= (cl == cr);
		end
	end

	assign corner = (eq_q[ahrq_pkg::BND_LOX] | eq_q[ahrq_pkg::BND_HIX])
		& (eq_q[ahrq_pkg::BND_LOY] | eq_q[ahrq_pkg::BND_HIY]);
	assign inner  = gt_q[ahrq_pkg::BND_LOX] & ~gt_q[ahrq_pkg::BND_HIX] & ~eq_q[ahrq_pkg::BND_HIX]
		& gt_q[ahrq_pkg::BND_LOY] & ~gt_q[ahrq_pkg::BND_HIY] & ~eq_q[ahrq_pkg::BND_HIY];

	assign sts.hit  = (&ok_q) & (corner | inner);
	assign sts.busy = rd_s1 | v_s2 | v_s3;

	// span divider: floor(num * 2^16 / (dlo * dhi)), zero when num <= 0, restoring, one bit a cycle
	logic [1:0]         lo_i, hi_i;
	logic signed [33:0] num_c, num_q;
	logic [31:0]        den_q, rem_q;
	logic [47:0]        dq_q;
	logic [32:0]        rem_sh, rem_sub;
	logic               ge;
	logic [32:0]        wq_q, hq_q;

	assign lo_i    = cmd.div_sel ? ahrq_pkg::BND_LOY : ahrq_pkg::BND_LOX;
	assign hi_i    = cmd.div_sel ? ahrq_pkg::BND_HIY : ahrq_pkg::BND_HIX;
	assign num_c   = bn_q[hi_i] * $signed({1'b0, bd_q[lo_i]})
		- bn_q[lo_i] * $signed({1'b0, bd_q[hi_i]});
	assign rem_sh  = {rem_q, dq_q[47]};
	assign ge      = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_num) begin
			num_q <= num_c;
		end
		if (cmd.div_den) begin
			den_q <= 32'(bd_q[lo_i] * bd_q[hi_i]);
			rem_q <= '0;
			dq_q  <= (num_q > 34'sd0) ? {num_q[31:0], 16'h0} : '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
			dq_q  <= {dq_q[46:0], ge};
		end
		if (cmd.div_save) begin
			if (cmd.div_sel) begin
				hq_q <= dq_q[32:0];
			end else begin
				wq_q <= dq_q[32:0];
			end
		end
	end

	// area in two partial products
	logic [49:0] p0_q, sum;
	logic [48:0] p1_q;

	assign sum = p0_q + {17'h0, p1_q[48:16]};

	always_ff @(posedge clk) begin
		if (cmd.mul0) begin
			p0_q <= wq_q * hq_q[32:16];
		end
		if (cmd.mul1) begin
			p1_q <= wq_q * hq_q[15:0];
		end
		if (cmd.out_load) begin
			out_data.inside_res <= sts.hit;
			out_data.area       <= sts.hit ? sum[AW-1:0] : '0;
		end
	end
endmodule

FILE: rtl/core/ahrq_ctrl.sv
// controller: request handshake, plane count and query sequencing
module ahrq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	output logic              out_valid,
	input  logic              out_stall,
	output ahrq_pkg::dp_cmd_t cmd,
	input  ahrq_pkg::dp_sts_t sts
);
	localparam int CW = ahrq_pkg::CNT_W;
	localparam int SW = ahrq_pkg::STEP_W;
	localparam int AW = ahrq_pkg::ADDR_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_DRAIN = 8'b0000_0100,
		S_CMP   = 8'b0000_1000,
		S_DIVX  = 8'b0001_0000,
		S_DIVY  = 8'b0010_0000,
		S_MUL   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t      state_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] cnt_q;
	logic          accept, out_free, scan_last;

	assign accept    = in_valid & ~in_stall;
	assign out_free  = ~out_valid | ~out_stall;
	assign scan_last = (cnt_q + SW'(1)) == SW'(count_q);

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && opcode == ahrq_pkg::OP_APPEND
					&& count_q < CW'(ahrq_pkg::MAX_PLANES)) begin
					cmd.wr   = 1'b1;
					cmd.addr = count_q[AW-1:0];
				end
				if (in_valid && opcode == ahrq_pkg::OP_QUERY) begin
					cmd.load = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.rd   = 1'b1;
				cmd.addr = cnt_q[AW-1:0];
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				cmd.sel = cnt_q[1:0];
			end
			S_DIVX, S_DIVY: begin
				cmd.div_sel  = (state_q == S_DIVY);
				cmd.div_num  = (cnt_q == SW'(0));
				cmd.div_den  = (cnt_q == SW'(1));
				cmd.div_step = (cnt_q > SW'(1)) && (cnt_q < SW'(ahrq_pkg::DIV_LAST));
				cmd.div_save = (cnt_q == SW'(ahrq_pkg::DIV_LAST));
			end
			S_MUL: begin
				cmd.mul0 = (cnt_q == SW'(0));
				cmd.mul1 = (cnt_q == SW'(1));
			end
			S_OUT: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (opcode == ahrq_pkg::OP_CLEAR) begin
							count_q <= '0;
						end
						if (cmd.wr) begin
							count_q <= count_q + CW'(1);
						end
						if (opcode == ahrq_pkg::OP_QUERY) begin
							state_q <= (count_q == '0) ? S_DRAIN : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
					cnt_q <= cnt_q + SW'(1);
				end
				S_DRAIN: begin
					cnt_q <= '0;
					if (!sts.busy) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (cnt_q == SW'(3)) begin
						state_q <= S_DIVX;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
				S_DIVX: begin
					if (cnt_q == SW'(0) && !sts.hit) begin
						state_q <= S_OUT;
					end else if (cnt_q == SW'(ahrq_pkg::DIV_LAST)) begin
						state_q <= S_DIVY;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
				S_DIVY: begin
					if (cnt_q == SW'(ahrq_pkg::DIV_LAST)) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
				S_MUL: begin
					if (cnt_q == SW'(1)) begin
						state_q <= S_OUT;
					end
					cnt_q <= cnt_q + SW'(1);
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/core/axis_halfplane_rectangle_query_unit.sv
// top level of the half-plane rectangle query unit
// Stores up to 256 half-planes a*x+b*y+c<=0 and answers point queries. A clear or
// an append request is handled as it is accepted; an append to a full table is
// dropped. After a query's result is loaded, the controller returns to idle, where
// it takes the next request. The scan reads one plane per cycle from the plane table
// through a three-stage compare pipeline. A drain state lets that pipeline empty.
// The point is then checked against each of the four bounds in turn. Two bit-serial
// divide passes, skipped when the point is rejected, form the width and the height,
// and two partial products multiply out the area. One request is worked on at a
// time. The result register lets a new request in while the last answer still waits
// to be taken.
module axis_halfplane_rectangle_query_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ahrq_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ahrq_pkg::out_rsp_t out_data
);
	ahrq_pkg::dp_cmd_t cmd;
	ahrq_pkg::dp_sts_t sts;

	// sequencing, plane count and handshakes
	ahrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (in_data.opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// plane table, bound tracking and area arithmetic
	ahrq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

	// a query holds off the next request
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.opcode == ahrq_pkg::OP_QUERY |=> in_stall)
		else $error("query accepted without stalling input");

	// no area without an accepted point
	a_area_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.inside_res |-> out_data.area == '0)
		else $error("area nonzero on rejected query");

	// area never above 2^48
	a_area_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.area <= 49'h1_0000_0000_0000)
		else $error("area out of range");
endmodule

FILE: tb/tb.sv
// testbench for the half-plane rectangle query unit
`timescale 1ns / 100ps

module tb;
	// opcode with no function
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// exact fraction bound n/d with d > 0
	typedef struct {
		bit     ok;
		longint n;
		longint d;
	} frac_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	ahrq_pkg::in_req_t  in_data;
	logic               out_valid;
	logic               out_stall;
	ahrq_pkg::out_rsp_t out_data;

	axis_halfplane_rectangle_query_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// predictor state: shadow plane table
	shortint  plane_a [ahrq_pkg::MAX_PLANES];
	shortint  plane_b [ahrq_pkg::MAX_PLANES];
	shortint  plane_c [ahrq_pkg::MAX_PLANES];
	int       plane_cnt;

	ahrq_pkg::in_req_t  req_q[$];       // requests waiting to be driven
	bit                 sync_q[$];      // request waits until all answers are back
	ahrq_pkg::out_rsp_t answer_q[$];    // predicted query answers, oldest first

	bit       req_taken;
	int       send_gap;
	int       recv_gap;
	int       hold_cycles;
	bit       hold_done;
	int       n_acc;
	int       fail_cnt;
	int       n_query;
	int       n_inside;
	int       n_dropped;

	// clock, 12 ns period
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic frac_t tighten(frac_t b, longint n, longint d, bit lower);
		longint l;
		longint r;
		if (!b.ok)
			return '{1'b1, n, d};
		l = n * b.d;
		r = b.n * d;
		if (lower ? (l > r) : (l < r))
			return '{1'b1, n, d};
		return b;
	endfunction

	// sign of p/2^16 - n/d
	function automatic int side_of(longint p, frac_t b);
		longint l;
		longint r;
		l = p * b.d;
		r = b.n * 65536;
		return (l > r) ? 1 : ((l < r) ? -1 : 0);
	endfunction

	// floor((hi - lo) * 2^16), zero when empty
	function automatic longint unsigned span_q16(frac_t lo, frac_t hi);
		longint num;
		num = hi.n * lo.d - lo.n * hi.d;
		if (num <= 0)
			return 0;
		return (longint'(num) * 65536) / (lo.d * hi.d);
	endfunction

	function automatic ahrq_pkg::out_rsp_t query_answer(longint px, longint py);
		frac_t              lox;
		frac_t              hix;
		frac_t              loy;
		frac_t              hiy;
		longint             a;
		longint             b;
		longint             c;
		int                 xl;
		int                 xh;
		int                 yl;
		int                 yh;
		bit                 corner;
		bit                 inner;
		longint unsigned    wq;
		longint unsigned    hq;
		longint unsigned    ar;
		ahrq_pkg::out_rsp_t rsp;
		lox = '{1'b0, 0, 1};
		hix = '{1'b0, 0, 1};
		loy = '{1'b0, 0, 1};
		hiy = '{1'b0, 0, 1};
		for (int i = 0; i < plane_cnt; i++) begin
			a = plane_a[i];
			b = plane_b[i];
			c = plane_c[i];
			if (a != 0) begin
				// plane must contain the point to count
				if (c * 65536 + a * px > 0)
					continue;
				if (a < 0)
					lox = tighten(lox, c, -a, 1'b1);
				else
					hix = tighten(hix, -c, a, 1'b0);
			end else if (b != 0) begin
				if (c * 65536 + b * py > 0)
					continue;
				if (b < 0)
					loy = tighten(loy, c, -b, 1'b1);
				else
					hiy = tighten(hiy, -c, b, 1'b0);
			end
			// a = b = 0: degenerate plane, skipped
		end
		rsp = '0;
		if (lox.ok && hix.ok && loy.ok && hiy.ok) begin
			xl = side_of(px, lox);
			xh = side_of(px, hix);
			yl = side_of(py, loy);
			yh = side_of(py, hiy);
			corner = (xl == 0 || xh == 0) && (yl == 0 || yh == 0);
			inner  = xl > 0 && xh < 0 && yl > 0 && yh < 0;
			if (corner || inner) begin
				wq = span_q16(lox, hix);
				hq = span_q16(loy, hiy);
				ar = wq * (hq >> 16) + ((wq * (hq & 64'hFFFF)) >> 16);
				rsp.inside_res = 1'b1;
				rsp.area       = ar[ahrq_pkg::AREA_W-1:0];
			end
		end
		return rsp;
	endfunction

	// update shadow state with one accepted request
	task automatic apply_request(input ahrq_pkg::in_req_t r);
		case (r.opcode)
			ahrq_pkg::OP_CLEAR:
				plane_cnt = 0;
			ahrq_pkg::OP_APPEND: begin
				if (plane_cnt < ahrq_pkg::MAX_PLANES) begin
					plane_a[plane_cnt] = r.coef_a;
					plane_b[plane_cnt] = r.coef_b;
					plane_c[plane_cnt] = r.coef_c;
					plane_cnt++;
				end else
					n_dropped++;
			end
			ahrq_pkg::OP_QUERY: begin
				answer_q = {answer_q,
					query_answer(longint'(r.query_x), longint'(r.query_y))};
				n_query++;
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_req(input logic [1:0] op, input int a, input int b, input int c,
			input int x, input int y, input bit sync = 1'b0);
		ahrq_pkg::in_req_t r;
		r.opcode  = op;
		r.coef_a  = a[15:0];
		r.coef_b  = b[15:0];
		r.coef_c  = c[15:0];
		r.query_x = x;
		r.query_y = y;
		req_q  = {req_q, r};
		sync_q = {sync_q, sync};
	endtask

	task automatic push_plane(input int a, input int b, input int c);
		push_req(ahrq_pkg::OP_APPEND, a, b, c, $urandom, $urandom);
	endtask

	task automatic push_query(input int x, input int y);
		push_req(ahrq_pkg::OP_QUERY, $urandom, $urandom, $urandom, x, y);
	endtask

	// divisor: often a power of two so corners are exactly representable
	function automatic int pick_div();
		if ($urandom_range(0, 1))
			return 1 << $urandom_range(0, 4);
		return $urandom_range(1, 40);
	endfunction

	// random plane: axis-parallel with small coefficients, degenerate, or with random coefficients
	task automatic push_noise_plane();
		int a;
		int b;
		case ($urandom_range(0, 4))
			0: begin a = $urandom_range(0, 20) - 10; b = 0; end
			1: begin a = 0; b = $urandom_range(0, 20) - 10; end
			2: begin a = 0; b = 0; end
			default: begin a = $signed(16'($urandom)); b = $signed(16'($urandom)); end
		endcase
		push_plane(a, b, $urandom_range(0, 4000) - 2000);
	endtask

	// one well-formed rectangle with queries; drop_side >= 0 leaves one side out
	task automatic push_rectangle(input bit do_clear, input int drop_side, input bit sync);
		int     dl;
		int     dh;
		int     el;
		int     eh;
		int     xlo;
		int     xhi;
		int     ylo;
		int     yhi;
		int     c_xl;
		int     c_xh;
		int     c_yl;
		int     c_yh;
		longint qxl;
		longint qxh;
		longint qyl;
		longint qyh;
		longint px;
		longint py;
		int     n_noise;
		dl  = pick_div();
		dh  = pick_div();
		el  = pick_div();
		eh  = pick_div();
		xlo = $urandom_range(0, 700) - 500;
		xhi = xlo + $urandom_range(1, 100);
		ylo = $urandom_range(0, 700) - 500;
		yhi = ylo + $urandom_range(1, 100);
		c_xl = xlo * dl + $urandom_range(0, dl - 1);
		c_xh = -(xhi * dh + $urandom_range(0, dh - 1));
		c_yl = ylo * el + $urandom_range(0, el - 1);
		c_yh = -(yhi * eh + $urandom_range(0, eh - 1));
		qxl = (longint'(c_xl) * 65536) / dl;
		qxh = (longint'(-c_xh) * 65536) / dh;
		qyl = (longint'(c_yl) * 65536) / el;
		qyh = (longint'(-c_yh) * 65536) / eh;
		if (do_clear)
			push_req(ahrq_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
				sync);
		n_noise = $urandom_range(0, 4);
		for (int i = 0; i < n_noise; i++)
			push_noise_plane();
		if (drop_side != 0) push_plane(-dl, 0, c_xl);
		if (drop_side != 1) push_plane(dh, 0, c_xh);
		if (drop_side != 2) push_plane(0, -el, c_yl);
		if (drop_side != 3) push_plane(0, eh, c_yh);
		if ($urandom_range(0, 2) == 0)
			push_noise_plane();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					// inside, or at most one unit past the upper bounds
					px = qxl + 1 + longint'($urandom_range(0, 32'(qxh - qxl)));
					py = qyl + 1 + longint'($urandom_range(0, 32'(qyh - qyl)));
				end
				2: begin
					// on a corner
					px = $urandom_range(0, 1) ? qxh : qxl;
					py = $urandom_range(0, 1) ? qyh : qyl;
				end
				3: begin
					// on an edge but not a corner
					px = $urandom_range(0, 1) ? qxh : qxl;
					py = (qyl + qyh) / 2;
				end
				4: begin
					// just outside
					px = qxh + $urandom_range(1, 70000);
					py = qyl - $urandom_range(0, 3);
				end
				default: begin
					px = $signed($urandom);
					py = $signed($urandom);
				end
			endcase
			push_query(int'(px), int'(py));
		end
	endtask

	// no idling near the end and in every fourth stretch of 80 requests
	function automatic bit quiet();
		return (req_q.size() < 150) || ((n_acc / 80) % 4 == 0);
	endfunction

	// ---------------------------------------------------------------
	// request generation, end of run
	// ---------------------------------------------------------------
	initial begin
		int kind;
		int n_seq;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		arst_n    = 1'b0;
		plane_cnt = 0;

		// directed: empty table, unused opcode, degenerate plane, extremes, corners
		push_query(0, 0);
		push_req(OP_UNUSED, -1, -1, -1, -1, -1);
		push_plane(-1, 0, -5);
		push_plane(1, 0, -5);
		push_plane(0, -1, -3);
		push_plane(0, 1, -3);
		push_plane(0, 0, 7);
		push_query(0, 0);
		push_query(5 << 16, 3 << 16);
		push_query(-5 << 16, -3 << 16);
		push_query(5 << 16, 0);
		push_query(32'h8000_0000, 32'h7fff_ffff);
		push_plane(-32768, 0, -32768);
		push_plane(32767, -32768, 32767);
		push_plane(0, 32767, -32768);
		push_plane(0, -32768, 32767);
		push_query(1 << 16, 0);
		push_query(32'h8000_0000, 32'h8000_0000);
		push_query(32'h7fff_ffff, 32'h7fff_ffff);
		push_req(ahrq_pkg::OP_CLEAR, -1, -1, -1, -1, -1);
		push_query(1 << 16, 0);
		push_req(OP_UNUSED, 0, 0, 0, 0, 0);

		// random: mostly rectangles, some broken ones and noise, one full table
		n_seq = 0;
		while (req_q.size() < 1550) begin
			n_seq++;
			if (n_seq == 40) begin
				push_req(ahrq_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
					$urandom, 1'b1);
				push_rectangle(1'b0, -1, 1'b0);
				repeat (ahrq_pkg::MAX_PLANES + 4)
					push_noise_plane();
				repeat (3)
					push_query($signed($urandom_range(0, 2000000)) - 1000000,
						$signed($urandom_range(0, 2000000)) - 1000000);
				push_req(ahrq_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
				continue;
			end
			kind = $urandom_range(0, 9);
			if (kind <= 6)
				push_rectangle($urandom_range(0, 4) != 0, -1, n_seq % 20 == 0);
			else if (kind == 7)
				push_rectangle(1'b1, $urandom_range(0, 3), 1'b0);
			else
				repeat ($urandom_range(1, 5))
					push_req(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_q.size() > 0 || in_valid || answer_q.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		$display("covered %0d requests, %0d queries (%0d inside), %0d appends to a full table",
			n_acc, n_query, n_inside, n_dropped);
		if (fail_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// timeout
	initial begin
		#200_000_000;
		$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// driver: requests change on the falling edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		bit calm;
		if (arst_n) begin
			calm = quiet();
			if (in_valid && !req_taken) begin
				// stalled request holds
			end else begin
				req_taken = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (req_q.size() > 0 && !(sync_q[0] && answer_q.size() > 0)) begin
					// a sync-marked request waits for every answer to drain
					in_data  <= req_q.pop_front();
					void'(sync_q.pop_front());
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 13);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver stall: one long hold-off, otherwise random bursts
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_acc >= 300) begin
				hold_done   = 1'b1;
				hold_cycles = 2000;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (!quiet() && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// monitor: handshakes sampled on the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		ahrq_pkg::out_rsp_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_request(in_data);
				req_taken = 1'b1;
				n_acc++;
			end
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					$error("answer with no query outstanding: inside_res=%0d area=%0d",
						out_data.inside_res, out_data.area);
					fail_cnt++;
				end else begin
					want = answer_q.pop_front();
					if (want.inside_res)
						n_inside++;
					if (out_data.inside_res !== want.inside_res) begin
						$error("inside_res: expected %0d, got %0d",
							want.inside_res, out_data.inside_res);
						fail_cnt++;
					end
					if (out_data.area !== want.area) begin
						$error("area: expected %0d, got %0d", want.area, out_data.area);
						fail_cnt++;
					end
				end
			end
		end
	end

endmodule

FILE: filelist.f
rtl/core/ahrq_pkg.sv
rtl/core/ahrq_ram.sv
rtl/core/ahrq_dp.sv
rtl/core/ahrq_ctrl.sv
rtl/core/axis_halfplane_rectangle_query_unit.sv
tb/tb.sv
